// ----- design/slab_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package slab_pkg;

    // Item kinds on the input channel.
    localparam logic [1:0] K_ALLOC = 2'd0;
    localparam logic [1:0] K_FREE  = 2'd1;
    localparam logic [1:0] K_ADD   = 2'd2;
    localparam logic [1:0] K_RSVD  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam int NUM_SLABS  = 4;
    localparam int SIZE_W     = 13;
    localparam int ADDR_W     = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_STK_DATA,
        S_SCAN,
        S_PG_DATA,
        S_FILE,
        S_FILE_PUSH,
        S_ADD,
        S_OUT
    } t_state;

    // Commands to the bucket head file.
    typedef struct packed {
        logic load;   // point the cursor at the given bucket
        logic step;   // advance the cursor by one bucket
        logic write;  // replace the head under the cursor
    } t_bkt_cmd;

    // Index of the highest set bit; zero for zero or one.
    function automatic logic [4:0] f_floor_log2(input logic [31:0] x);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 1; i < 32; i++) begin
            if (x[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/slab_allocator_with_page_buckets.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// input     in         i_in_valid / o_in_stall  i_kind, i_slab, i_address
// output    out        o_out_valid / i_out_stall o_object_address, o_status
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item is handled at a time; the input is stalled until its result transfer.
// Frees, refused requests and unused kinds go from dispatch straight to the output;
// a page add passes S_ADD and a stack pop S_STK_DATA on the way. A carve scans up to
// PAGE_SHIFT_BITS+1 buckets with the single bucket cursor, then uses the page memory port.
// Reset is synchronous and active low; it empties all buckets and stacks, with no sweep.
// A stalled result holds in the output register until it is taken.

module slab_allocator_with_page_buckets
    import slab_pkg::*;
#(
    parameter int PAGE_SHIFT_BITS = 12,
    parameter int FREE_DEPTH      = 64,
    parameter int MAX_PAGES       = 64,
    parameter int ENTRY_HEADER    = 8,
    parameter int PAGE_HEADER     = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_kind,
    input  wire logic [1:0]        i_slab,
    input  wire logic [ADDR_W-1:0] i_address,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [ADDR_W-1:0]      o_object_address,
    output logic [1:0]             o_status,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [SIZE_W-1:0] i_cfg_data
);

    localparam int NB    = PAGE_SHIFT_BITS + 1;
    localparam int BW    = $clog2(NB);
    localparam int PW    = $clog2(MAX_PAGES + 1);
    localparam int PAW   = $clog2(MAX_PAGES);
    localparam int LW    = PAGE_SHIFT_BITS;
    localparam int DW    = (LW > SIZE_W) ? LW : SIZE_W;
    localparam int CW    = $clog2(FREE_DEPTH + 1);
    localparam int SAW   = $clog2(NUM_SLABS * FREE_DEPTH);
    localparam int PGW   = ADDR_W + LW + PW;
    localparam int LEFT0 = (1 << PAGE_SHIFT_BITS) - PAGE_HEADER;
    localparam logic [BW-1:0] B0 = BW'(f_floor_log2(32'(LEFT0)));

    t_state r_state, n_state;

    // Per-item registers.
    logic [1:0]        r_kind, r_slab;
    logic [ADDR_W-1:0] r_addr;
    logic [SIZE_W-1:0] r_size;
    logic [ADDR_W-1:0] r_res, n_res;
    logic [1:0]        r_status, n_status;
    logic [PW-1:0]     r_page, n_page;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [LW-1:0]     r_left, n_left;

    // Allocator state.
    logic [SIZE_W-1:0] r_entry [NUM_SLABS];
    logic [CW-1:0]     r_cnt   [NUM_SLABS];
    logic [PW-1:0]     r_used;

    // Strobes from the sequencer.
    logic w_accept, w_cnt_inc, w_cnt_dec, w_used_inc;

    // Stack memory port.
    logic            w_stk_we;
    logic [SAW-1:0]  w_stk_base, w_stk_waddr, w_stk_raddr;
    logic [ADDR_W-1:0] w_stk_rdata;

    // Page memory port.
    logic            w_pg_we;
    logic [PAW-1:0]  w_pg_waddr, w_pg_raddr;
    logic [PGW-1:0]  w_pg_wdata, w_pg_rdata;
    logic [ADDR_W-1:0] w_pg_base;
    logic [LW-1:0]   w_pg_left, w_left_new;
    logic [PW-1:0]   w_pg_next;

    // Bucket head file.
    t_bkt_cmd        w_bcmd;
    logic [BW-1:0]   w_bidx;
    logic [PW-1:0]   w_bwdata, w_bhead;
    logic            w_bhit, w_blast;

    logic [CW-1:0]   w_cnt_cur;

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = (r_state == S_OUT);
    assign o_object_address = r_res;
    assign o_status         = r_status;
    assign o_cfg_ready      = 1'b1;
    assign w_accept         = i_in_valid && (r_state == S_IDLE);

    assign w_cnt_cur   = r_cnt[r_slab];
    assign w_stk_base  = SAW'(r_slab) * SAW'(FREE_DEPTH);
    assign w_stk_waddr = w_stk_base + SAW'(w_cnt_cur);
    assign w_stk_raddr = w_stk_base + SAW'(w_cnt_cur) - SAW'(1);

    assign w_pg_base  = w_pg_rdata[PGW-1 -: ADDR_W];
    assign w_pg_left  = w_pg_rdata[LW+PW-1 -: LW];
    assign w_pg_next  = w_pg_rdata[PW-1:0];
    // The bucket lower bound guarantees the size fits in the page remainder.
    assign w_left_new = LW'(DW'(w_pg_left) - DW'(r_size));

    slab_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (NUM_SLABS * FREE_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (r_addr),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    slab_ram #(
        .WIDTH (PGW),
        .DEPTH (MAX_PAGES)
    ) u_pages (
        .i_clk   (i_clk),
        .i_we    (w_pg_we),
        .i_waddr (w_pg_waddr),
        .i_wdata (w_pg_wdata),
        .i_raddr (w_pg_raddr),
        .o_rdata (w_pg_rdata)
    );

    slab_bucket #(
        .PAGE_SHIFT_BITS (PAGE_SHIFT_BITS),
        .MAX_PAGES       (MAX_PAGES)
    ) u_bucket (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_bcmd),
        .i_idx   (w_bidx),
        .i_wdata (w_bwdata),
        .i_size  (r_size),
        .o_head  (w_bhead),
        .o_hit   (w_bhit),
        .o_last  (w_blast)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            for (int i = 0; i < NUM_SLABS; i++) begin
                r_entry[i] <= SIZE_W'(64);
                r_cnt[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_entry[i_cfg_index] <= i_cfg_data;
            end
            if (w_cnt_inc) begin
                r_cnt[r_slab] <= w_cnt_cur + CW'(1);
            end else if (w_cnt_dec) begin
                r_cnt[r_slab] <= w_cnt_cur - CW'(1);
            end
            if (w_used_inc) begin
                r_used <= r_used + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_kind;
            r_slab <= i_slab;
            r_addr <= i_address;
            r_size <= r_entry[i_slab];
        end
        r_res    <= n_res;
        r_status <= n_status;
        r_page   <= n_page;
        r_base   <= n_base;
        r_left   <= n_left;
    end

    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        n_status   = r_status;
        n_page     = r_page;
        n_base     = r_base;
        n_left     = r_left;
        w_cnt_inc  = 1'b0;
        w_cnt_dec  = 1'b0;
        w_used_inc = 1'b0;
        w_stk_we   = 1'b0;
        w_pg_we    = 1'b0;
        w_pg_waddr = r_page[PAW-1:0];
        w_pg_wdata = {r_base, r_left, w_bhead};
        w_pg_raddr = w_bhead[PAW-1:0];
        w_bcmd     = '0;
        w_bidx     = '0;
        w_bwdata   = r_page;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res    = '0;
                    n_status = ST_OK;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_OUT;
                case (r_kind)
                    K_ALLOC: begin
                        if (w_cnt_cur != '0) begin
                            w_cnt_dec = 1'b1;
                            n_state   = S_STK_DATA;
                        end else if (r_size == '0) begin
                            n_status = ST_OOM;
                        end else begin
                            w_bcmd.load = 1'b1;
                            w_bidx      = '0;
                            n_state     = S_SCAN;
                        end
                    end
                    K_FREE: begin
                        if (w_cnt_cur >= CW'(FREE_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_stk_we  = 1'b1;
                            w_cnt_inc = 1'b1;
                        end
                    end
                    K_ADD: begin
                        if (r_used >= PW'(MAX_PAGES)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_bcmd.load = 1'b1;
                            w_bidx      = B0;
                            n_state     = S_ADD;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_STK_DATA: begin
                n_res   = w_stk_rdata;
                n_state = S_OUT;
            end
            S_SCAN: begin
                if (w_bhit) begin
                    // The head page is read now and unlinked next cycle.
                    n_page  = w_bhead;
                    n_state = S_PG_DATA;
                end else if (w_blast) begin
                    n_status = ST_OOM;
                    n_state  = S_OUT;
                end else begin
                    w_bcmd.step = 1'b1;
                end
            end
            S_PG_DATA: begin
                w_bcmd.write = 1'b1;
                w_bwdata     = w_pg_next;
                n_base       = w_pg_base;
                n_left       = w_left_new;
                n_res        = w_pg_base + ADDR_W'(PAGE_HEADER + ENTRY_HEADER)
                               + ADDR_W'(w_left_new);
                n_state      = S_FILE;
            end
            S_FILE: begin
                if (r_left != '0) begin
                    w_bcmd.load = 1'b1;
                    w_bidx      = BW'(f_floor_log2(32'(r_left)));
                    n_state     = S_FILE_PUSH;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_FILE_PUSH: begin
                w_pg_we      = 1'b1;
                w_bcmd.write = 1'b1;
                w_bwdata     = r_page;
                n_state      = S_OUT;
            end
            S_ADD: begin
                w_pg_we      = 1'b1;
                w_pg_waddr   = r_used[PAW-1:0];
                w_pg_wdata   = {r_addr, LW'(LEFT0), w_bhead};
                w_bcmd.write = 1'b1;
                w_bwdata     = r_used;
                w_used_inc   = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/slab_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/slab_bucket.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slab_bucket
    import slab_pkg::*;
#(
    parameter int PAGE_SHIFT_BITS = 12,
    parameter int MAX_PAGES       = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire t_bkt_cmd                              i_cmd,
    input  wire logic [$clog2(PAGE_SHIFT_BITS+1)-1:0]  i_idx,
    input  wire logic [$clog2(MAX_PAGES+1)-1:0]        i_wdata,
    input  wire logic [SIZE_W-1:0]                     i_size,
    output logic      [$clog2(MAX_PAGES+1)-1:0]        o_head,
    output logic                                       o_hit,
    output logic                                       o_last
);

    localparam int NB    = PAGE_SHIFT_BITS + 1;
    localparam int BW    = $clog2(NB);
    localparam int PW    = $clog2(MAX_PAGES + 1);
    localparam int CMPW  = (NB > SIZE_W) ? NB : SIZE_W;
    localparam logic [PW-1:0] EMPTY = PW'(MAX_PAGES);

    logic [PW-1:0]   r_head [NB];
    logic [BW-1:0]   r_idx;
    logic [CMPW-1:0] w_pow;

    // The cursor is the only read port of the head file.
    assign o_head = r_head[r_idx];
    assign w_pow  = CMPW'(1) << r_idx;
    // A bucket qualifies when it holds a page and its lower bound covers the size.
    assign o_hit  = (o_head != EMPTY) && (w_pow >= CMPW'(i_size));
    assign o_last = (r_idx == BW'(NB - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NB; i++) begin
                r_head[i] <= EMPTY;
            end
            r_idx <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= i_idx;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + BW'(1);
            end
            if (i_cmd.write) begin
                r_head[r_idx] <= i_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import slab_pkg::*;

    localparam int PAGE_SHIFT_BITS = 12;
    localparam int FREE_DEPTH      = 64;
    localparam int MAX_PAGES       = 64;
    localparam int ENTRY_HEADER    = 8;
    localparam int PAGE_HEADER     = 16;
    localparam int NUM_BUCKETS     = PAGE_SHIFT_BITS + 1;
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 40;

    // One predicted answer of the allocator.
    typedef struct {
        logic [ADDR_W-1:0] object_address;
        logic [1:0]        status;
    } grant_t;

    // Mirror of the allocator state plus the queue of answers still owed.
    class alloc_scoreboard;
        logic [SIZE_W-1:0] entry_bytes [NUM_SLABS];
        logic [ADDR_W-1:0] stack_mem   [NUM_SLABS][FREE_DEPTH];
        logic [6:0]        stack_fill  [NUM_SLABS];
        logic [ADDR_W-1:0] pg_base     [MAX_PAGES];
        logic [SIZE_W-1:0] pg_left     [MAX_PAGES];
        logic [6:0]        pg_link     [MAX_PAGES];
        logic [6:0]        bkt_head    [NUM_BUCKETS];
        logic [6:0]        pg_count;
        grant_t            owed [$];
        int                errors;

        function new();
            for (int i = 0; i < NUM_SLABS; i++) begin
                entry_bytes[i] = 64;
                stack_fill[i]  = 0;
            end
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                bkt_head[b] = 7'(MAX_PAGES);
            end
            pg_count = 0;
            errors   = 0;
        endfunction

        function int hi_bit(input int unsigned x);
            int n;
            n = 0;
            while (x > 1) begin
                x = x >> 1;
                n++;
            end
            return n;
        endfunction

        // Put a page on the list for floor(log2 remaining), clamped to the top bucket.
        function void refile(input int p);
            int b;
            b = hi_bit(pg_left[p]);
            if (b >= NUM_BUCKETS) begin
                b = NUM_BUCKETS - 1;
            end
            pg_link[p]  = bkt_head[b];
            bkt_head[b] = 7'(p);
        endfunction

        function void set_entry_bytes(input logic [1:0] idx, input logic [SIZE_W-1:0] v);
            entry_bytes[idx] = v;
        endfunction

        // Advance the mirror by one accepted request and queue its answer.
        function void note_request(input logic [1:0] kind, input logic [1:0] slab,
                                   input logic [ADDR_W-1:0] addr);
            grant_t g;
            int unsigned size;
            int b0;
            int p;
            bit found;
            g.object_address = '0;
            g.status         = ST_OK;
            size             = entry_bytes[slab];
            if (kind == K_ALLOC) begin
                if (stack_fill[slab] > 0) begin
                    stack_fill[slab]--;
                    g.object_address = stack_mem[slab][stack_fill[slab]];
                end else if (size == 0) begin
                    g.status = ST_OOM;
                end else begin
                    found = 0;
                    b0 = (size <= 1) ? 0 : hi_bit(size - 1) + 1;
                    for (int b = b0; b < NUM_BUCKETS && !found; b++) begin
                        p = bkt_head[b];
                        if (p < MAX_PAGES) begin
                            bkt_head[b] = pg_link[p];
                            pg_left[p]  = pg_left[p] - SIZE_W'(size);
                            g.object_address = pg_base[p] + PAGE_HEADER + pg_left[p]
                                               + ENTRY_HEADER;
                            if (pg_left[p] > 0) begin
                                refile(p);
                            end
                            found = 1;
                        end
                    end
                    if (!found) begin
                        g.status = ST_OOM;
                    end
                end
            end else if (kind == K_FREE) begin
                if (stack_fill[slab] >= FREE_DEPTH) begin
                    g.status = ST_FULL;
                end else begin
                    stack_mem[slab][stack_fill[slab]] = addr;
                    stack_fill[slab]++;
                end
            end else if (kind == K_ADD) begin
                if (pg_count >= MAX_PAGES) begin
                    g.status = ST_FULL;
                end else begin
                    p = pg_count;
                    pg_count++;
                    pg_base[p] = addr;
                    pg_left[p] = SIZE_W'((1 << PAGE_SHIFT_BITS) - PAGE_HEADER);
                    pg_link[p] = 7'(MAX_PAGES);
                    if (pg_left[p] > 0) begin
                        refile(p);
                    end
                end
            end
            owed.push_back(g);
        endfunction

        function void check_result(input logic [ADDR_W-1:0] addr, input logic [1:0] st);
            grant_t g;
            if (owed.size() == 0) begin
                $error("unexpected result: object_address %h status %0d", addr, st);
                errors++;
                return;
            end
            g = owed.pop_front();
            if (addr !== g.object_address) begin
                $error("object_address: expected %h, actual %h", g.object_address, addr);
                errors++;
            end
            if (st !== g.status) begin
                $error("status: expected %0d, actual %0d", g.status, st);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_kind = K_ALLOC;
    logic [1:0]        i_slab = 2'd0;
    logic [ADDR_W-1:0] i_address = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [ADDR_W-1:0] o_object_address;
    logic [1:0]        o_status;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index = 2'd0;
    logic [SIZE_W-1:0] i_cfg_data = '0;

    alloc_scoreboard sb = new();

    // Idle percentages for the current phase, and bookkeeping for the watchdog.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    bit timed_out = 0;

    // Addresses handed out so far; frees mostly return one of these.
    logic [ADDR_W-1:0] live_objs [$];

    always #5 i_clk = ~i_clk;

    slab_allocator_with_page_buckets #(
        .PAGE_SHIFT_BITS(PAGE_SHIFT_BITS),
        .FREE_DEPTH(FREE_DEPTH),
        .MAX_PAGES(MAX_PAGES),
        .ENTRY_HEADER(ENTRY_HEADER),
        .PAGE_HEADER(PAGE_HEADER)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_kind(i_kind),
        .i_slab(i_slab),
        .i_address(i_address),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_object_address(o_object_address),
        .o_status(o_status),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // Result side: check every output transfer, then pick the stall for the next cycle.
    // Values read right after the edge are the ones that were present at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_object_address, o_status);
                if (o_status == ST_OK && o_object_address != 0) begin
                    live_objs.push_back(o_object_address);
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // The watchdog counts cycles in which no transfer happens on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Present one request and hold it until the transfer. Valid only drops during an
    // idle gap, so a back-to-back request never lowers and raises it in one step.
    task automatic send_req(input logic [1:0] kind, input logic [1:0] slab,
                            input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_slab     <= slab;
        i_address  <= addr;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sb.note_request(kind, slab, addr);
    endtask

    // Wait for every owed answer, then give any internal work time to settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Registers are only written with the allocator idle. Valid stays high between
    // back-to-back writes; the caller lowers it after the last one.
    task automatic write_size(input logic [1:0] idx, input logic [SIZE_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        sb.set_entry_bytes(idx, v);
    endtask

    // A free usually returns a live object so pops hand back real addresses.
    task automatic random_req(input int free_pct);
        int roll;
        int pick;
        logic [ADDR_W-1:0] a;
        roll = $urandom_range(99);
        a = $urandom();
        if (roll < 8) begin
            send_req(K_ADD, 2'($urandom()), {a[31:12], 12'h000} ^ ($urandom_range(3) == 0 ? a : 0));
        end else if (roll < 11) begin
            send_req(K_RSVD, 2'($urandom()), a);
        end else if (roll < 11 + free_pct) begin
            if (live_objs.size() > 0 && $urandom_range(9) < 7) begin
                pick = $urandom_range(live_objs.size() - 1);
                a = live_objs[pick];
                live_objs.delete(pick);
            end
            send_req(K_FREE, 2'($urandom()), a);
        end else begin
            send_req(K_ALLOC, 2'($urandom()), a);
        end
    endtask

    initial begin
        int sizes [6][4];
        sizes = '{'{64, 64, 64, 64}, '{1, 4096, 0, 8191}, '{4096, 1, 8191, 0},
                  '{24, 100, 2048, 4080}, '{4081, 2047, 17, 9}, '{64, 8, 512, 1}};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening with the reset sizes: nothing to carve, pop of a freed
        // address, carving from a page at the top of the address space, an unused
        // kind, and a free stack pushed past its depth.
        send_req(K_ALLOC, 2'd0, 32'h0);
        send_req(K_FREE, 2'd0, 32'hFFFF_FFFF);
        send_req(K_ALLOC, 2'd0, 32'h0);
        send_req(K_ADD, 2'd3, 32'hFFFF_F000);
        send_req(K_ALLOC, 2'd1, 32'h0);
        send_req(K_ALLOC, 2'd2, 32'hFFFF_FFFF);
        send_req(K_ADD, 2'd0, 32'h0000_0000);
        send_req(K_RSVD, 2'd3, 32'hFFFF_FFFF);
        send_req(K_ALLOC, 2'd3, 32'h0);
        for (int i = 0; i < FREE_DEPTH + 2; i++) begin
            send_req(K_FREE, 2'd1, $urandom());
        end
        drain();

        // Each phase picks a size set and an idling mix; two phases lean to frees so
        // the stacks fill, and adds over the run fill the page store.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 56;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 56;
                end
                default: begin
                    send_idle_pct = 11;
                    recv_stall_pct = 11;
                end
            endcase
            for (int s = 0; s < NUM_SLABS; s++) begin
                if (ph < 6) begin
                    write_size(2'(s), SIZE_W'(sizes[ph][s]));
                end else begin
                    write_size(2'(s), SIZE_W'($urandom_range(1, 300)));
                end
            end
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < 130; n++) begin
                random_req((ph == 5 || ph == 9) ? 70 : 38);
                if (n == 60 && ph == 3) begin
                    // Hold off until the allocator has answered everything.
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (sb.owed.size() != 0) begin
                        @(posedge i_clk);
                    end
                end
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
